/* hw/rtl/irq_pending_latch_multiplexer_unit_defines.svh */
// Assertion macros for the interrupt pending register block.
// Used by the top level only; the bodies are empty when SYNTHESIS is defined.
`ifndef IRQ_PENDING_LATCH_MULTIPLEXER_UNIT_DEFINES_SVH
`define IRQ_PENDING_LATCH_MULTIPLEXER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define PLM_ASSERT_IMPL(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define PLM_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) cond |=> prop) else $error(msg);
`else
`define PLM_ASSERT_IMPL(label, prop, msg)
`define PLM_ASSERT_NEXT(label, cond, prop, msg)
`endif
`endif

/* hw/rtl/plm_pkg.sv */
// Package for the interrupt pending register block: line count, codes and
// the structs passed between the modules. No dependencies.
`default_nettype none
package plm_pkg;
    localparam int NUM_LINES  = 32;
    localparam int LINE_IDX_W = 5;
    localparam int COUNT_W    = 6;
    localparam int MODES_W    = 64;
    localparam int MASK_W     = 32;
    localparam int PEND_W     = 32;
    localparam int CFG_DATA_W = 64;
    localparam int IN_DATA_W  = 40;

    localparam logic CFG_LINE_COUNT = 1'b0;
    localparam logic CFG_LINE_MODES = 1'b1;

    localparam logic [COUNT_W-1:0] LINE_COUNT_RESET = COUNT_W'(32);

    typedef enum logic [1:0] {
        KIND_LEVEL = 2'd0,
        KIND_ACK   = 2'd1,
        KIND_CLEAR = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        MODE_LEVEL   = 2'd0,
        MODE_RISING  = 2'd1,
        MODE_FALLING = 2'd2,
        MODE_HOLD    = 2'd3
    } t_mode;

    typedef struct packed {
        logic [1:0]            kind;
        logic [LINE_IDX_W-1:0] line;
        logic                  level;
        logic [MASK_W-1:0]     mask_value;
    } t_event;

    typedef struct packed {
        logic [COUNT_W-1:0] line_count;
        logic [MODES_W-1:0] line_modes;
    } t_cfg;
endpackage
`default_nettype wire

/* hw/rtl/plm_cfg_regs.sv */
// Configuration registers of the interrupt pending register block.
// Depends on plm_pkg.
`default_nettype none
module plm_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_index,
    input  wire logic [plm_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output plm_pkg::t_cfg                       o_cfg
);
    logic [plm_pkg::COUNT_W-1:0] r_line_count;
    logic [plm_pkg::MODES_W-1:0] r_line_modes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_count <= plm_pkg::LINE_COUNT_RESET;
            r_line_modes <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                plm_pkg::CFG_LINE_COUNT: r_line_count <= i_cfg_wdata[plm_pkg::COUNT_W-1:0];
                plm_pkg::CFG_LINE_MODES: r_line_modes <= i_cfg_wdata[plm_pkg::MODES_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.line_count = r_line_count;
    assign o_cfg.line_modes = r_line_modes;
endmodule
`default_nettype wire

/* hw/rtl/plm_core.sv */
// Line state and event logic: levels, per-line pending bits, summary vector.
// Depends on plm_pkg.
`default_nettype none
module plm_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_fire,
    input  wire plm_pkg::t_event            i_event,
    input  wire plm_pkg::t_cfg              i_cfg,
    output logic [plm_pkg::PEND_W-1:0]      o_pending
);
    localparam int N = plm_pkg::NUM_LINES;

    logic [N-1:0] r_levels, n_levels;
    logic [N-1:0] r_line_pend, n_line_pend;
    logic [N-1:0] r_vector, n_vector;
    logic [N-1:0] sel;
    logic [N-1:0] new_pend;
    logic [N-1:0] below;
    logic         line_ok;

    assign line_ok = ({1'b0, i_event.line} < (plm_pkg::LINE_IDX_W + 1)'(N));

    always_comb begin
        for (int i = 0; i < N; i++) begin
            sel[i]   = line_ok && (i_event.line == plm_pkg::LINE_IDX_W'(i));
            // Lines below the count are the ones whose per-line pending bit an acknowledge may clear;
            // a count above the line total covers every line.
            below[i] = (plm_pkg::COUNT_W'(i) < i_cfg.line_count);
            case (plm_pkg::t_mode'(i_cfg.line_modes[2*i +: 2]))
                plm_pkg::MODE_LEVEL:   new_pend[i] = i_event.level;
                plm_pkg::MODE_RISING:  new_pend[i] = r_line_pend[i] |
                                                     (!r_levels[i] && i_event.level);
                plm_pkg::MODE_FALLING: new_pend[i] = r_line_pend[i] |
                                                     (r_levels[i] && !i_event.level);
                default:               new_pend[i] = r_line_pend[i];
            endcase
        end

        n_levels    = r_levels;
        n_line_pend = r_line_pend;
        n_vector    = r_vector;
        case (plm_pkg::t_kind'(i_event.kind))
            plm_pkg::KIND_LEVEL: begin
                n_levels    = (r_levels & ~sel) | (sel & {N{i_event.level}});
                n_line_pend = (r_line_pend & ~sel) | (sel & new_pend);
                n_vector    = (r_vector & ~sel) | (sel & new_pend);
            end
            plm_pkg::KIND_ACK: begin
                n_vector    = r_vector & i_event.mask_value[N-1:0];
                n_line_pend = r_line_pend & (i_event.mask_value[N-1:0] | ~below);
            end
            plm_pkg::KIND_CLEAR: begin
                n_levels    = '0;
                n_line_pend = '0;
                n_vector    = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels    <= '0;
            r_line_pend <= '0;
            r_vector    <= '0;
        end else if (i_fire) begin
            r_levels    <= n_levels;
            r_line_pend <= n_line_pend;
            r_vector    <= n_vector;
        end
    end

    assign o_pending = plm_pkg::PEND_W'(n_vector);
endmodule
`default_nettype wire

/* hw/rtl/irq_pending_latch_multiplexer_unit.sv */
// Interrupt pending register over up to 32 lines with per-line trigger modes.
// An accepted word goes to the input register, and its result to the output register.
// Throughput: one word per cycle unless the output stalls; the input register
// takes a new word when it is empty or the output register is empty or drained.
// Reset (synchronous, active low): levels and pending bits cleared, line count
// set to 32, all lines in level mode. Depends on plm_pkg, plm_cfg_regs, plm_core.
`default_nettype none
`include "irq_pending_latch_multiplexer_unit_defines.svh"
module irq_pending_latch_multiplexer_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // tdata from bit 0: line[4:0], level[5], mask_value[37:6], zero fill[39:38].
    input  wire logic [plm_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // tuser: kind[1:0].
    input  wire logic [1:0]                     i_s_tuser,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // tdata: pending[31:0].
    output logic [plm_pkg::PEND_W-1:0]          o_m_tdata,
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_index,
    input  wire logic [plm_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    plm_pkg::t_cfg                 cfg;
    plm_pkg::t_event               r_event;
    logic                          r_in_valid;
    logic                          r_out_valid;
    logic [plm_pkg::PEND_W-1:0]    r_out_data;
    logic [plm_pkg::PEND_W-1:0]    result;
    logic                          advance;
    logic                          fire;
    logic                          take;

    assign advance    = !r_out_valid || i_m_tready;
    assign fire       = r_in_valid && advance;
    assign o_s_tready = !r_in_valid || advance;
    assign take       = i_s_tvalid && o_s_tready;

    plm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    plm_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_event   (r_event),
        .i_cfg     (cfg),
        .o_pending (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_event.kind       <= i_s_tuser;
            r_event.line       <= i_s_tdata[4:0];
            r_event.level      <= i_s_tdata[5];
            r_event.mask_value <= i_s_tdata[37:6];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // A blocked word must stay in the input register.
    `PLM_ASSERT_NEXT(a_in_hold, r_in_valid && !advance, r_in_valid, "input word lost while stalled")
    // Every word that leaves the input register shows up as a result.
    `PLM_ASSERT_NEXT(a_fire_out, fire, o_m_tvalid, "result missing after event")
    // A clear event leaves an all-zero summary vector.
    `PLM_ASSERT_NEXT(a_clear_zero, fire && (r_event.kind == plm_pkg::KIND_CLEAR), o_m_tdata == '0, "summary not zero after clear")
    // Input back-pressure only when both registers are occupied.
    `PLM_ASSERT_IMPL(a_ready, !o_s_tready |-> (r_in_valid && r_out_valid), "ready low without a full pipe")
endmodule
`default_nettype wire
